FILE: rtl/rgcp_pkg.sv
// Shared types and constants of the ray grid cube picker.
package rgcp_pkg;

  // Port field widths
  localparam int OW    = 32;   // origin, Q16.16
  localparam int DIRW  = 18;   // direction, Q1.16
  localparam int GSW   = 6;    // grid_size register
  localparam int SPW   = 24;   // cell_spacing register, Q8.16
  localparam int CIDXW = 2;    // configuration register index
  localparam int IN_W  = 152;  // input tdata, padded to bytes
  localparam int OUT_W = 48;   // output tdata

  // Configuration register indexes
  localparam logic [CIDXW-1:0] REG_GRID_SIZE    = 2'd0;
  localparam logic [CIDXW-1:0] REG_CELL_SPACING = 2'd1;

  localparam logic [GSW-1:0] GRID_SIZE_RESET = 6'd0;
  localparam logic [SPW-1:0] SPACING_RESET   = 24'd78643;

  // Internal arithmetic: slab differences, dividend magnitude and slab t
  localparam int DW  = 35;          // bound - origin, signed
  localparam int CPW = DW - 1;      // cube centre position, unsigned
  localparam int NW  = DW + 16;     // |difference| * 65536
  localparam int TW  = 56;          // slab t, signed
  localparam int DCW = 6;           // divider step counter

  localparam logic signed [DW-1:0] HALF_SIDE = 35'sd32768;
  localparam logic signed [TW-1:0] T_INF     = 56'sh20_0000_0000_0000;
  localparam logic signed [TW-1:0] T_NINF    = -56'sh20_0000_0000_0000;
  localparam logic signed [TW-1:0] SAT_MAX   = 56'sh00_0000_7FFF_FFFF;
  localparam logic signed [TW-1:0] SAT_MIN   = -56'sh00_0000_8000_0000;

  // One ray after classification
  typedef struct packed {
    logic [2:0][OW-1:0]   org;
    logic [2:0][DIRW-1:0] dir;
    logic [2:0]           dzero;
  } ray_t;

  // One slab interval of one cube index on one axis
  typedef struct packed {
    logic                 ok;
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
  } slab_t;

  // Divider request
  typedef struct packed {
    logic                   start;
    logic signed [DW-1:0]   num;
    logic signed [DIRW-1:0] den;
  } div_req_t;

  // Pick result
  typedef struct packed {
    logic [OW-1:0] distance;
    logic [4:0]    cz;
    logic [4:0]    cy;
    logic [4:0]    cx;
    logic          hit;
  } result_t;

endpackage

FILE: rtl/rgcp_front.sv
// Input stage: takes ray beats and classifies the direction components.
module rgcp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rgcp_pkg::IN_W-1:0] in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rgcp_pkg::ray_t            out_ray
);

  rgcp_pkg::ray_t ray_c;
  logic           valid;

  // Unpack fields and flag zero direction components
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ray_c.org[a]   = in_data[a*rgcp_pkg::OW +: rgcp_pkg::OW];
      ray_c.dir[a]   = in_data[3*rgcp_pkg::OW + a*rgcp_pkg::DIRW +: rgcp_pkg::DIRW];
      ray_c.dzero[a] = (ray_c.dir[a] == '0);
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_ray <= ray_c;
    end
  end

endmodule

FILE: rtl/rgcp_queue.sv
// Two-entry queue of classified rays between front and back.
module rgcp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rgcp_pkg::ray_t in_ray,
  output logic           out_valid,
  input  logic           out_ready,
  output rgcp_pkg::ray_t out_ray
);

  rgcp_pkg::ray_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_ray   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_ray;
    end
  end

endmodule

FILE: rtl/rgcp_div.sv
// Serial signed divider, one quotient bit a cycle, truncating toward zero.
module rgcp_div (
  input  logic                               clk,
  input  logic                               rst,
  input  rgcp_pkg::div_req_t                 req,
  output logic                               done,
  output logic signed [rgcp_pkg::TW-1:0]     quot
);

  localparam int NW   = rgcp_pkg::NW;
  localparam int DW   = rgcp_pkg::DW;
  localparam int DIRW = rgcp_pkg::DIRW;
  localparam int TW   = rgcp_pkg::TW;

  logic                     run;
  logic [rgcp_pkg::DCW-1:0] cnt;
  logic [NW-1:0]            qr;
  logic [DIRW-1:0]          rem;
  logic [DIRW-1:0]          dmag;
  logic                     neg;
  logic [DIRW:0]            sh;
  logic                     ge;
  logic [DIRW:0]            diff;
  logic [DW-1:0]            nmag;
  logic [TW-1:0]            qext;

  // Operand magnitudes
  assign nmag = req.num[DW-1] ? DW'(-req.num) : DW'(req.num);

  // One restoring step
  assign sh   = {rem, qr[NW-1]};
  assign ge   = (sh >= {1'b0, dmag});
  assign diff = sh - {1'b0, dmag};

  assign qext = {{(TW-NW){1'b0}}, qr};
  assign quot = neg ? $signed(-qext) : $signed(qext);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= rgcp_pkg::DCW'(NW - 1);
      end else if (run) begin
        cnt <= cnt - rgcp_pkg::DCW'(1);
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      qr   <= {nmag, 16'b0};
      rem  <= '0;
      dmag <= req.den[DIRW-1] ? DIRW'(-req.den) : DIRW'(req.den);
      neg  <= req.num[DW-1] ^ req.den[DIRW-1];
    end else if (run) begin
      qr  <= {qr[NW-2:0], ge};
      rem <= ge ? diff[DIRW-1:0] : sh[DIRW-1:0];
    end
  end

endmodule

FILE: rtl/rgcp_back.sv
// Back end: builds per-axis slab tables, sweeps all cubes, holds the result.
module rgcp_back #(
  parameter int GRID_MAX = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rgcp_pkg::GSW-1:0]  grid_size,
  input  logic [rgcp_pkg::SPW-1:0]  cell_spacing,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rgcp_pkg::ray_t            in_ray,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rgcp_pkg::result_t         out_result
);

  localparam int CW  = $clog2(GRID_MAX + 1);
  localparam int IW  = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int DW  = rgcp_pkg::DW;
  localparam int TW  = rgcp_pkg::TW;
  localparam int CPW = rgcp_pkg::CPW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BLD   = 3'd1;
  localparam logic [2:0] S_DLO   = 3'd2;
  localparam logic [2:0] S_DHI   = 3'd3;
  localparam logic [2:0] S_SWP   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state;
  rgcp_pkg::ray_t       ray;
  logic [CW-1:0]        n;
  logic [CW-1:0]        n_c;
  logic [1:0]           axis;
  logic [CW-1:0]        m;
  logic [CPW-1:0]       cpos;
  logic signed [TW-1:0] ta;

  // Slab tables, one per axis
  rgcp_pkg::slab_t mem_x [GRID_MAX];
  rgcp_pkg::slab_t mem_y [GRID_MAX];
  rgcp_pkg::slab_t mem_z [GRID_MAX];

  logic                 wr_en;
  rgcp_pkg::slab_t      wr_entry;
  logic signed [DW-1:0] o;
  logic signed [DW-1:0] lo;
  logic signed [DW-1:0] hi;
  logic                 dz;
  logic                 m_last;

  rgcp_pkg::div_req_t   dreq;
  logic                 ddone;
  logic signed [TW-1:0] dquot;

  // Sweep counters and pipeline
  logic [CW-1:0]        ci, cj, ck;
  logic                 v1, v2, v3;
  logic [2:0][CW-1:0]   idx1, idx2, idx3;
  rgcp_pkg::slab_t      rdx, rdy, rdz;
  logic                 ok2;
  logic signed [TW-1:0] e0, e1;
  rgcp_pkg::slab_t      z2;
  logic                 ok3;
  logic signed [TW-1:0] en, ex;
  logic                 found;
  logic signed [TW-1:0] best;
  logic [2:0][CW-1:0]   bidx;
  logic                 take;

  logic signed [TW-1:0] sat;
  logic [31:0]          bx32, by32, bz32;

  // Clamp grid size to the table depth
  always_comb begin
    if (32'(grid_size) > GRID_MAX) n_c = CW'(GRID_MAX);
    else                           n_c = CW'(grid_size);
  end

  // Slab bounds of the current table entry
  assign o  = $signed({{(DW-rgcp_pkg::OW){ray.org[axis][rgcp_pkg::OW-1]}}, ray.org[axis]});
  assign lo = $signed({1'b0, cpos}) - rgcp_pkg::HALF_SIDE;
  assign hi = $signed({1'b0, cpos}) + rgcp_pkg::HALF_SIDE;
  assign dz = ray.dzero[axis];
  assign m_last = (m == n - CW'(1));

  assign dreq.start = (state == S_BLD && !dz) || (state == S_DLO && ddone);
  assign dreq.num   = (state == S_BLD) ? (lo - o) : (hi - o);
  assign dreq.den   = $signed(ray.dir[axis]);

  rgcp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  // Table write data
  always_comb begin
    wr_en    = 1'b0;
    wr_entry = '0;
    if (state == S_BLD && dz) begin
      wr_en       = 1'b1;
      wr_entry.ok = (o >= lo) && (o <= hi);
      wr_entry.t0 = rgcp_pkg::T_NINF;
      wr_entry.t1 = rgcp_pkg::T_INF;
    end else if (state == S_DHI && ddone) begin
      wr_en       = 1'b1;
      wr_entry.ok = 1'b1;
      wr_entry.t0 = (ta < dquot) ? ta : dquot;
      wr_entry.t1 = (ta < dquot) ? dquot : ta;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && axis == 2'd0) mem_x[m[IW-1:0]] <= wr_entry;
    if (wr_en && axis == 2'd1) mem_y[m[IW-1:0]] <= wr_entry;
    if (wr_en && axis == 2'd2) mem_z[m[IW-1:0]] <= wr_entry;
    rdx <= mem_x[ci[IW-1:0]];
    rdy <= mem_y[cj[IW-1:0]];
    rdz <= mem_z[ck[IW-1:0]];
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (n_c == '0) ? S_DONE : S_BLD;
          end
        end
        S_BLD: begin
          if (!dz) state <= S_DLO;
          else if (m_last && axis == 2'd2) state <= S_SWP;
        end
        S_DLO: begin
          if (ddone) state <= S_DHI;
        end
        S_DHI: begin
          if (ddone) state <= (m_last && axis == 2'd2) ? S_SWP : S_BLD;
        end
        S_SWP: begin
          if (ck == n - CW'(1) && cj == n - CW'(1) && ci == n - CW'(1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!v1 && !v2 && !v3) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Table build counters and ray capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      ray  <= in_ray;
      n    <= n_c;
      axis <= 2'd0;
      m    <= '0;
      cpos <= '0;
    end
    if (state == S_DLO && ddone) begin
      ta <= dquot;
    end
    if (wr_en) begin
      if (m_last) begin
        m    <= '0;
        cpos <= '0;
        axis <= axis + 2'd1;
      end else begin
        m    <= m + CW'(1);
        cpos <= cpos + CPW'(cell_spacing);
      end
    end
  end

  // Sweep issue counters, x outermost then y then z
  always_ff @(posedge clk) begin
    if (state != S_SWP) begin
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else if (ck == n - CW'(1)) begin
      ck <= '0;
      if (cj == n - CW'(1)) begin
        cj <= '0;
        ci <= ci + CW'(1);
      end else begin
        cj <= cj + CW'(1);
      end
    end else begin
      ck <= ck + CW'(1);
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= (state == S_SWP);
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 2: combine x and y slabs; stage 3: fold in z
  always_ff @(posedge clk) begin
    idx1 <= {ck, cj, ci};
    idx2 <= idx1;
    idx3 <= idx2;
    ok2  <= rdx.ok && rdy.ok;
    e0   <= (rdx.t0 > rdy.t0) ? rdx.t0 : rdy.t0;
    e1   <= (rdx.t1 < rdy.t1) ? rdx.t1 : rdy.t1;
    z2   <= rdz;
    ok3  <= ok2 && z2.ok;
    en   <= (e0 > z2.t0) ? e0 : z2.t0;
    ex   <= (e1 < z2.t1) ? e1 : z2.t1;
  end

  // Stage 4: nearest hit, first cube wins ties
  assign take = v3 && ok3 && (en <= ex) && (ex >= 0) && (!found || en < best);

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take) begin
      best <= (en >= 0) ? en : ex;
      bidx <= idx3;
    end
  end

  // Result register
  assign sat  = (best > rgcp_pkg::SAT_MAX) ? rgcp_pkg::SAT_MAX :
                (best < rgcp_pkg::SAT_MIN) ? rgcp_pkg::SAT_MIN : best;
  assign bx32 = 32'(bidx[0]);
  assign by32 = 32'(bidx[1]);
  assign bz32 = 32'(bidx[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      if (found) begin
        out_result.hit      <= 1'b1;
        out_result.cx       <= bx32[4:0];
        out_result.cy       <= by32[4:0];
        out_result.cz       <= bz32[4:0];
        out_result.distance <= sat[rgcp_pkg::OW-1:0];
      end else begin
        out_result <= '0;
      end
    end
  end

endmodule

FILE: rtl/ray_grid_cube_pick.sv
// Ray pick against a cubic grid of cubes: top level with configuration registers.
// One ray beat gives one result beat. Per ray the back end first builds three slab
// tables with a one-bit-a-cycle divider, two divisions for each cell index on each
// axis whose direction is nonzero, then sweeps all n^3 cubes one per cycle through
// a four-stage compare pipeline; n is grid_size clamped to GRID_MAX. A two-entry
// queue and an input register hold further rays meanwhile, and the result waits
// in its own register. Configuration writes are taken in any cycle.
module ray_grid_cube_pick #(
  parameter int GRID_MAX = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 2 bits zero pad
  input  logic [rgcp_pkg::IN_W-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // hit, cell_x, cell_y, cell_z, hit_distance
  output logic [rgcp_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgcp_pkg::CIDXW-1:0]        cfg_index,
  input  logic [rgcp_pkg::SPW-1:0]          cfg_data
);

  logic [rgcp_pkg::GSW-1:0] grid_size;
  logic [rgcp_pkg::SPW-1:0] cell_spacing;

  logic              f_valid, f_ready;
  rgcp_pkg::ray_t    f_ray;
  logic              q_valid, q_ready;
  rgcp_pkg::ray_t    q_ray;
  rgcp_pkg::result_t result;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size    <= rgcp_pkg::GRID_SIZE_RESET;
      cell_spacing <= rgcp_pkg::SPACING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rgcp_pkg::REG_GRID_SIZE:    grid_size    <= cfg_data[rgcp_pkg::GSW-1:0];
        rgcp_pkg::REG_CELL_SPACING: cell_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  rgcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_ray   (f_ray)
  );

  rgcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_ray    (f_ray),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_ray   (q_ray)
  );

  rgcp_back #(
    .GRID_MAX (GRID_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .grid_size    (grid_size),
    .cell_spacing (cell_spacing),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_ray       (q_ray),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_result   (result)
  );

  assign m_axis_tdata = result;

endmodule

FILE: rtl/rgcp_checker.sv
// Port-level checks of the ray picker, bound to the top level.
module rgcp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rgcp_pkg::OUT_W-1:0]        m_axis_tdata
);

  // A stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // A miss reports zero cell and distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[rgcp_pkg::OUT_W-1:1] == '0)
    else $error("miss with nonzero fields");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

endmodule

bind ray_grid_cube_pick rgcp_checker u_rgcp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
